// ===== rtl/core/jsu_pkg.sv =====
// Shared types, constants and functions for the JSON string unescape block.
// Used by jsu_front, jsu_fifo, jsu_back and json_string_unescape_utf8_top.
// No dependencies.
`default_nettype none

package jsu_pkg;

   // Decoder modes. Codes 6 and 7 are never entered and behave as normal copying.
   localparam logic [2:0] MODE_NORMAL  = 3'd0;
   localparam logic [2:0] MODE_ESCAPE  = 3'd1;
   localparam logic [2:0] MODE_HEX1    = 3'd2;
   localparam logic [2:0] MODE_HIGH    = 3'd3;
   localparam logic [2:0] MODE_HIGH_BS = 3'd4;
   localparam logic [2:0] MODE_HEX2    = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd0;
   localparam logic [1:0] ERR_BAD_UNICODE  = 2'd1;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   // Surrogate bounds and the combine offset: 0x10000 - 0xDC00 folded together.
   localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
   localparam logic [20:0] PAIR_OFFSET   = 21'h002400;

   localparam int unsigned MAX_RESULTS = 4;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic [1:0] err;
   } jsu_result_type;

   // All results caused by one input word, in order from index 0.
   typedef struct packed {
      logic [2:0]                           count;
      jsu_result_type [MAX_RESULTS-1:0]     res;
   } jsu_bundle_type;

   typedef struct packed {
      logic [2:0]       count;
      logic [3:0][7:0]  bytes;
   } jsu_utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] digit;
   } jsu_hex_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jsu_q_status_type;

   function automatic jsu_utf8_type utf8_encode(input logic [20:0] cp);
      jsu_utf8_type enc;
      enc = '0;
      if (cp < 21'h80) begin
         enc.count    = 3'd1;
         enc.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         enc.count    = 3'd2;
         enc.bytes[0] = {3'b110, cp[10:6]};
         enc.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         enc.count    = 3'd3;
         enc.bytes[0] = {4'b1110, cp[15:12]};
         enc.bytes[1] = {2'b10, cp[11:6]};
         enc.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         enc.count    = 3'd4;
         enc.bytes[0] = {5'b11110, cp[20:18]};
         enc.bytes[1] = {2'b10, cp[17:12]};
         enc.bytes[2] = {2'b10, cp[11:6]};
         enc.bytes[3] = {2'b10, cp[5:0]};
      end
      return enc;
   endfunction

   function automatic jsu_hex_type hex_value(input logic [7:0] c);
      jsu_hex_type h;
      h = '0;
      if (c inside {[8'h30:8'h39]}) begin
         h.ok    = 1'b1;
         h.digit = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         h.ok    = 1'b1;
         h.digit = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/json_string_unescape_utf8_top.sv =====
// An accepted word's first result passes the bundle queue, then the output register.
// Throughput: one result word per cycle while rsp_ready is high, set by the single
// output register; words with zero or one result can enter every cycle.
// The bundle queue (QUEUE_DEPTH entries) lets the decoder run ahead while the output stalls.
// Reset is synchronous: decoder returns to normal copying, queue and output are emptied.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
`default_nettype none

module json_string_unescape_utf8_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_text_ended,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_kind,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last
);
   import jsu_pkg::*;

   logic             accept;
   logic             q_push;
   logic             q_pop;
   jsu_bundle_type   push_bundle;
   jsu_bundle_type   head_bundle;
   jsu_q_status_type q_status;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .text_ended (req_text_ended),
      .push       (q_push),
      .bundle     (push_bundle)
   );

   jsu_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_bundle),
      .pop       (q_pop),
      .head      (head_bundle),
      .status    (q_status)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head_bundle),
      .q_status       (q_status),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // An end or error result always closes the results of its word.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_last)
      else $error("end or error result without last");

   // A pushed bundle carries between one and four results.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      q_push |-> push_bundle.count != 3'd0 && push_bundle.count <= 3'd4)
      else $error("bundle result count out of range");

   // The serializer only pops a queue that holds a bundle.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // Data results carry a zero error code.
   a_data_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |-> rsp_error_code == ERR_BAD_ESCAPE)
      else $error("data result with nonzero error code");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/jsu_front.sv =====
// Front end: escape decoding state machine that turns one input word into a
// bundle of up to four results. Depends on jsu_pkg.
`default_nettype none

module jsu_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             in_byte,
   input  wire logic                   text_ended,
   output logic                        push,
   output jsu_pkg::jsu_bundle_type     bundle
);
   import jsu_pkg::*;

   logic [2:0]  mode_ff, mode_in;
   logic [1:0]  digit_ff, digit_in;
   logic [15:0] cp_ff, cp_in;
   logic [15:0] high_ff, high_in;

   jsu_hex_type  hexv;
   logic [15:0]  cp_shift;
   logic [20:0]  pair_cp;
   jsu_utf8_type enc_hex, enc_pair, enc_high, enc_sel;

   logic                             pre;
   logic                             do_fail, do_norm, do_esc, do_enc, use_pair;
   logic [1:0]                       fail_code;
   logic [2:0]                       tail_cnt;
   jsu_result_type [MAX_RESULTS-1:0] tail;

   assign hexv     = hex_value(in_byte);
   assign cp_shift = {cp_ff[11:0], hexv.digit};
   // The high half is known to lie in the surrogate range, so its offset is its low ten bits.
   assign pair_cp  = {1'b0, high_ff[9:0], 10'b0} + {5'b0, cp_shift} + PAIR_OFFSET;
   assign enc_hex  = utf8_encode({5'b0, cp_shift});
   assign enc_pair = utf8_encode(pair_cp);
   assign enc_high = utf8_encode({5'b0, high_ff});
   assign enc_sel  = use_pair ? enc_pair : enc_hex;

   always_comb begin
      mode_in   = mode_ff;
      digit_in  = digit_ff;
      cp_in     = cp_ff;
      high_in   = high_ff;
      pre       = 1'b0;
      do_fail   = 1'b0;
      do_norm   = 1'b0;
      do_esc    = 1'b0;
      do_enc    = 1'b0;
      use_pair  = 1'b0;
      fail_code = ERR_BAD_ESCAPE;
      tail_cnt  = 3'd0;
      tail      = '0;

      if (text_ended) begin
         do_fail = 1'b1;
         case (mode_ff)
            MODE_ESCAPE: fail_code = ERR_BAD_ESCAPE;
            MODE_HEX1, MODE_HEX2: fail_code = ERR_BAD_UNICODE;
            MODE_HIGH: begin
               pre       = 1'b1;
               fail_code = ERR_UNTERMINATED;
            end
            MODE_HIGH_BS: begin
               pre       = 1'b1;
               fail_code = ERR_BAD_ESCAPE;
            end
            default: fail_code = ERR_UNTERMINATED;
         endcase
      end else begin
         case (mode_ff)
            MODE_ESCAPE: do_esc = 1'b1;
            MODE_HEX1, MODE_HEX2: begin
               if (!hexv.ok) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_BAD_UNICODE;
               end else begin
                  cp_in = cp_shift;
                  if (digit_ff != 2'd3) begin
                     digit_in = digit_ff + 2'd1;
                  end else begin
                     digit_in = 2'd0;
                     if (mode_ff == MODE_HEX1 &&
                         cp_shift >= HIGH_SURR_MIN && cp_shift <= HIGH_SURR_MAX) begin
                        high_in = cp_shift;
                        mode_in = MODE_HIGH;
                     end else begin
                        do_enc   = 1'b1;
                        use_pair = (mode_ff == MODE_HEX2);
                        mode_in  = MODE_NORMAL;
                     end
                  end
               end
            end
            MODE_HIGH: begin
               if (in_byte == CH_BACKSLASH) begin
                  mode_in = MODE_HIGH_BS;
               end else begin
                  pre     = 1'b1;
                  do_norm = 1'b1;
               end
            end
            MODE_HIGH_BS: begin
               if (in_byte == CH_U) begin
                  mode_in  = MODE_HEX2;
                  digit_in = 2'd0;
                  cp_in    = 16'd0;
               end else begin
                  pre    = 1'b1;
                  do_esc = 1'b1;
               end
            end
            default: do_norm = 1'b1;
         endcase
      end

      if (do_norm) begin
         mode_in = MODE_NORMAL;
         if (in_byte == CH_QUOTE) begin
            tail[0]  = '{data: 8'd0, kind: KIND_END, err: ERR_BAD_ESCAPE};
            tail_cnt = 3'd1;
         end else if (in_byte == CH_BACKSLASH) begin
            mode_in = MODE_ESCAPE;
         end else begin
            tail[0]  = '{data: in_byte, kind: KIND_DATA, err: ERR_BAD_ESCAPE};
            tail_cnt = 3'd1;
         end
      end

      if (do_esc) begin
         mode_in  = MODE_NORMAL;
         tail_cnt = 3'd1;
         tail[0]  = '{data: 8'd0, kind: KIND_DATA, err: ERR_BAD_ESCAPE};
         case (in_byte)
            CH_QUOTE:     tail[0].data = CH_QUOTE;
            CH_BACKSLASH: tail[0].data = CH_BACKSLASH;
            CH_SLASH:     tail[0].data = CH_SLASH;
            CH_B:         tail[0].data = 8'h08;
            CH_F:         tail[0].data = 8'h0C;
            CH_N:         tail[0].data = 8'h0A;
            CH_R:         tail[0].data = 8'h0D;
            CH_T:         tail[0].data = 8'h09;
            CH_U: begin
               tail_cnt = 3'd0;
               mode_in  = MODE_HEX1;
               digit_in = 2'd0;
               cp_in    = 16'd0;
            end
            default: begin
               tail_cnt  = 3'd0;
               do_fail   = 1'b1;
               fail_code = ERR_BAD_ESCAPE;
            end
         endcase
      end

      if (do_fail) begin
         tail[0]  = '{data: 8'd0, kind: KIND_ERROR, err: fail_code};
         tail_cnt = 3'd1;
         mode_in  = MODE_NORMAL;
         digit_in = 2'd0;
      end

      if (do_enc) begin
         tail_cnt = enc_sel.count;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            tail[i] = '{data: enc_sel.bytes[i], kind: KIND_DATA, err: ERR_BAD_ESCAPE};
         end
      end
   end

   // A pending high surrogate is always three bytes and leaves room for one more result.
   always_comb begin
      if (pre) begin
         bundle.count = 3'd3 + tail_cnt;
         for (int i = 0; i < 3; i++) begin
            bundle.res[i] = '{data: enc_high.bytes[i], kind: KIND_DATA, err: ERR_BAD_ESCAPE};
         end
         bundle.res[3] = tail[0];
      end else begin
         bundle.count = tail_cnt;
         bundle.res   = tail;
      end
   end

   assign push = accept && (bundle.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         digit_ff <= 2'd0;
         cp_ff    <= 16'd0;
         high_ff  <= 16'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         cp_ff    <= cp_in;
         high_ff  <= high_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_fifo.sv =====
// Short bundle queue between the decoder front end and the output serializer.
// Depends on jsu_pkg.
`default_nettype none

module jsu_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire jsu_pkg::jsu_bundle_type    push_data,
   input  wire logic                       pop,
   output jsu_pkg::jsu_bundle_type         head,
   output jsu_pkg::jsu_q_status_type       status
);
   import jsu_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   jsu_bundle_type  mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   assign wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head         = mem_ff[rd_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_back.sv =====
// Back end: walks the head bundle one result per cycle, while the output is not stalled, into the output register.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire jsu_pkg::jsu_bundle_type    head,
   input  wire jsu_pkg::jsu_q_status_type  q_status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic [1:0]                      rsp_kind,
   output logic [1:0]                      rsp_error_code,
   output logic                            rsp_last
);
   import jsu_pkg::*;

   logic [1:0]     idx_ff, idx_in;
   logic           valid_ff, valid_in;
   jsu_result_type res_ff;
   logic           last_ff;
   logic           load;
   logic           at_last;

   assign load    = !q_status.empty && (!valid_ff || rsp_ready);
   assign at_last = ({1'b0, idx_ff} + 3'd1) == head.count;
   assign pop     = load && at_last;
   assign idx_in  = at_last ? 2'd0 : idx_ff + 2'd1;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.res[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = res_ff.data;
   assign rsp_kind       = res_ff.kind;
   assign rsp_error_code = res_ff.err;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire
